FILE: rtl/atht_pkg.sv
// Shared types and constants for the address tally hash table.
package atht_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 128;

    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 40;
    localparam int ALLOC_W  = 32;
    localparam int ACTIVE_W = 8;

    // Fibonacci hashing multiplier, 2^64 divided by the golden ratio
    localparam logic [63:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

    typedef enum logic [1:0] {
        SLOT_FREE   = 2'd0,
        SLOT_ACTIVE = 2'd1,
        SLOT_TOMB   = 2'd2
    } t_slot;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_QUERY  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FOUND     = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef struct packed {
        t_slot                st;
        logic [ADDR_W-1:0]    addr;
        logic [SIZE_W-1:0]    size;
        logic [ALLOC_W-1:0]   alloc;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: rtl/atht_ram.sv
// Generic simple dual-port RAM with registered read.
module atht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/atht_hash.sv
// Iterative home-slot unit: shared 32x32 multiplier, then bit-serial reduction for a non-power-of-two depth.
module atht_hash
    import atht_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ADDR_W-1:0]              i_addr,
    output logic                           o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_slot
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam bit IS_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);

    typedef enum logic [1:0] {
        H_IDLE,
        H_MUL,
        H_MOD
    } t_hstate;

    t_hstate           r_state;
    logic              r_done;
    logic [ADDR_W-1:0] r_a;
    logic [1:0]        r_step;
    logic [5:0]        r_bit;
    logic [63:0]       r_prod;
    logic [63:0]       r_acc;
    logic [IDX_W-1:0]  r_rem;

    logic [31:0]       w_mul_a;
    logic [31:0]       w_mul_b;
    logic [IDX_W:0]    w_rem2;

    // Low 64 bits of a*C = a0*c0 + ((a0*c1 + a1*c0) << 32)
    always_comb begin
        unique case (r_step)
            2'd0: begin
                w_mul_a = r_a[31:0];
                w_mul_b = HASH_MULT[31:0];
            end
            2'd1: begin
                w_mul_a = r_a[31:0];
                w_mul_b = HASH_MULT[63:32];
            end
            default: begin
                w_mul_a = {16'b0, r_a[47:32]};
                w_mul_b = HASH_MULT[31:0];
            end
        endcase
    end

    assign w_rem2 = {r_rem, r_acc[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
            r_bit   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                H_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_addr;
                        r_step  <= '0;
                        r_state <= H_MUL;
                    end
                end
                H_MUL: begin
                    r_prod <= w_mul_a * w_mul_b;
                    unique case (r_step)
                        2'd0:    r_acc <= r_acc;
                        2'd1:    r_acc <= r_prod;
                        default: r_acc <= r_acc + {r_prod[31:0], 32'b0};
                    endcase
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        if (IS_POW2) begin
                            r_done  <= 1'b1;
                            r_state <= H_IDLE;
                        end else begin
                            r_rem   <= '0;
                            r_bit   <= 6'd63;
                            r_state <= H_MOD;
                        end
                    end
                end
                H_MOD: begin
                    // restoring reduction, one product bit per cycle, MSB first
                    if (w_rem2 >= (IDX_W+1)'(TABLE_DEPTH)) begin
                        r_rem <= IDX_W'(w_rem2 - (IDX_W+1)'(TABLE_DEPTH));
                    end else begin
                        r_rem <= w_rem2[IDX_W-1:0];
                    end
                    r_acc <= {r_acc[62:0], 1'b0};
                    r_bit <= r_bit - 6'd1;
                    if (r_bit == 6'd0) begin
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end
                end
                default: r_state <= H_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_slot = IS_POW2 ? r_acc[IDX_W-1:0] : r_rem;

endmodule

FILE: rtl/address_tally_hash_table_top.sv
// Top level of the address tally: linear-probing hash table of live blocks.
//
// Input stream (s_axis): one beat is one operation. tuser carries the kind
// (insert or update, remove, query; the unused code answers "not found"),
// tdata carries the block address and the block size.
// Output stream (m_axis): one result beat per operation, in order. tuser is
// the status code, tdata holds allocation number, found size, running byte
// total and active count.
// The home slot is formed on the shared 32x32 multiplier, followed by
// bit-serial reduction when TABLE_DEPTH is not a power of two. Each probe
// then reads the table and compares the entry, an insert adds a write
// state, and the result is registered before it is sent. The probe loop
// through the single table read port sets the rate, worst case one full pass.
// s_axis tready is high only between operations. After reset the block sweeps
// the table once to mark every slot free, with tready low.
// A stalled receiver holds the result register; the next operation is still
// accepted and runs up to its own result, which waits for the register.
module address_tally_hash_table_top
    import atht_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [87:0]  i_s_axis_tdata,   // address[47:0], block_size[87:48]
    input  logic [1:0]   i_s_axis_tuser,   // kind[1:0]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // alloc_number[31:0], found_size[71:32],
                                           // total_bytes[119:72], active_count[127:120]
    output logic [2:0]   o_m_axis_tuser    // status[2:0]
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_ISSUE,
        S_CHECK,
        S_COMMIT,
        S_RESP
    } t_state;

    t_state               r_state;
    logic [1:0]           r_kind;
    logic [ADDR_W-1:0]    r_addr;
    logic [SIZE_W-1:0]    r_size;
    logic [IDX_W-1:0]     r_pos;
    logic [CNT_W-1:0]     r_cnt;
    t_status              r_status;
    logic [ALLOC_W-1:0]   r_alloc;
    logic [SIZE_W-1:0]    r_fsize;
    logic [ADDR_W-1:0]    r_total;
    logic [CNT_W-1:0]     r_live;
    logic [ALLOC_W-1:0]   r_next_alloc;
    logic                 r_ovalid;
    logic [127:0]         r_odata;
    t_status              r_ouser;

    logic                 w_s_acc;
    logic                 w_kind_ok;
    logic                 w_hash_done;
    logic [IDX_W-1:0]     w_hash_slot;
    logic [ENTRY_W-1:0]   w_rdata;
    t_entry               w_entry;
    logic                 w_free;
    logic                 w_match;
    logic                 w_last;
    logic                 w_we;
    t_entry               w_wentry;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_s_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_kind_ok = (i_s_axis_tuser == KIND_INSERT) || (i_s_axis_tuser == KIND_REMOVE)
                    || (i_s_axis_tuser == KIND_QUERY);

    atht_hash #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_s_acc && w_kind_ok),
        .i_addr  (i_s_axis_tdata[47:0]),
        .o_done  (w_hash_done),
        .o_slot  (w_hash_slot)
    );

    atht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pos),
        .i_wdata (w_wentry),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    assign w_entry = t_entry'(w_rdata);
    assign w_free  = (w_entry.st == SLOT_FREE);
    assign w_match = (w_entry.st == SLOT_ACTIVE) && (w_entry.addr == r_addr);
    assign w_last  = (r_cnt == CNT_W'(TABLE_DEPTH - 1));

    // Table write: clearing sweep, tombstone on remove hit, entry on insert
    always_comb begin
        w_we     = 1'b0;
        w_wentry = w_entry;
        unique case (r_state)
            S_CLEAR: begin
                w_we     = 1'b1;
                w_wentry = '0;
            end
            S_CHECK: begin
                w_we        = w_match && (r_kind == KIND_REMOVE);
                w_wentry.st = SLOT_TOMB;
            end
            S_COMMIT: begin
                w_we     = 1'b1;
                w_wentry = '{st: SLOT_ACTIVE, addr: r_addr, size: r_size, alloc: r_alloc};
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_pos        <= '0;
            r_cnt        <= '0;
            r_total      <= '0;
            r_live       <= '0;
            r_next_alloc <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_pos <= r_pos + IDX_W'(1);
                    if (r_pos == IDX_W'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_kind   <= i_s_axis_tuser;
                        r_addr   <= i_s_axis_tdata[47:0];
                        r_size   <= i_s_axis_tdata[87:48];
                        r_status <= ST_NOT_FOUND;
                        r_alloc  <= '0;
                        r_fsize  <= '0;
                        r_state  <= w_kind_ok ? S_HASH : S_RESP;
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_pos   <= w_hash_slot;
                        r_cnt   <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    priority if (w_free) begin
                        // free slot ends the probe; an insert takes it
                        if (r_kind == KIND_INSERT) begin
                            r_status <= ST_NEW;
                            r_alloc  <= r_next_alloc;
                            r_state  <= S_COMMIT;
                        end else begin
                            r_state <= S_RESP;
                        end
                    end else if (w_match) begin
                        priority case (r_kind)
                            KIND_INSERT: begin
                                r_status <= ST_UPDATED;
                                r_alloc  <= w_entry.alloc;
                                r_total  <= r_total - {8'b0, w_entry.size};
                                r_state  <= S_COMMIT;
                            end
                            KIND_REMOVE: begin
                                r_status <= ST_REMOVED;
                                r_total  <= r_total - {8'b0, w_entry.size};
                                r_live   <= r_live - CNT_W'(1);
                                r_state  <= S_RESP;
                            end
                            default: begin
                                r_status <= ST_FOUND;
                                r_fsize  <= w_entry.size;
                                r_state  <= S_RESP;
                            end
                        endcase
                    end else if (w_last) begin
                        // full pass without a free slot or a match
                        if (r_kind == KIND_INSERT) begin
                            r_status <= ST_FULL;
                        end
                        r_state <= S_RESP;
                    end else begin
                        r_pos   <= (r_pos == IDX_W'(TABLE_DEPTH - 1)) ? '0 : r_pos + IDX_W'(1);
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_state <= S_ISSUE;
                    end
                end
                S_COMMIT: begin
                    r_total <= r_total + {8'b0, r_size};
                    if (r_status == ST_NEW) begin
                        r_live       <= r_live + CNT_W'(1);
                        r_next_alloc <= r_next_alloc + ALLOC_W'(1);
                    end
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    // load the result register once it is free or being drained
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {ACTIVE_W'(r_live), r_total, r_fsize, r_alloc};
                        r_ouser  <= r_status;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

`ifndef ASSERT_OFF
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(TABLE_DEPTH))
        else $error("live count exceeds table depth");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_cnt < CNT_W'(TABLE_DEPTH)))
        else $error("probe ran past one full pass");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_HASH || r_state == S_RESP) |-> !w_we)
        else $error("table written outside an operation");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_FULL)) |-> (o_m_axis_tdata[71:0] == '0))
        else $error("full result carries allocation or size");

    a_new_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT && r_status == ST_NEW) |=> (r_live == $past(r_live) + CNT_W'(1)))
        else $error("new entry not counted");
`endif

endmodule
